// File: sv/appbc_pkg.sv
// ----------------------------------------------------------------------------
// appbc_pkg
// Types and constants shared by the audio ping-pong buffer controller.
// ----------------------------------------------------------------------------
package appbc_pkg;

    localparam int MAX_BUFFER_SAMPLES = 4096;
    localparam int COUNT_W            = 13;
    localparam int KIND_W             = 2;

    localparam logic [COUNT_W-1:0] SAMPLES_RESET = COUNT_W'(256);
    localparam logic [COUNT_W-1:0] SAMPLES_MAX   = COUNT_W'(MAX_BUFFER_SAMPLES);
    localparam logic [COUNT_W-1:0] SAMPLES_MIN   = COUNT_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_FILLED = 2'd1,
        KIND_PLAYED = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Phase of one playback buffer.
    typedef enum logic [3:0] {
        PH_EMPTY   = 4'b0001,
        PH_FILLING = 4'b0010,
        PH_FULL    = 4'b0100,
        PH_PLAYING = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               buf_index;
        logic [COUNT_W-1:0] fill_count;
    } event_t;

    typedef struct packed {
        logic               fill_request;
        logic               fill_target;
        logic               pad_needed;
        logic [COUNT_W-1:0] pad_start;
        logic               move_to_first;
        logic               output_start;
        logic               output_stop;
        logic               underrun;
        logic               stream_done;
        logic               event_error;
    } result_t;

endpackage

// File: sv/appbc_if.sv
// ----------------------------------------------------------------------------
// appbc channel interfaces
// Valid/ready channels for events, command results and the size register.
// ----------------------------------------------------------------------------
interface appbc_event_if;
    logic              valid;
    logic              ready;
    appbc_pkg::event_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface appbc_result_if;
    logic               valid;
    logic               ready;
    appbc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface appbc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [appbc_pkg::COUNT_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/audio_ping_pong_buffer_controller_unit.sv
// ----------------------------------------------------------------------------
// audio_ping_pong_buffer_controller_unit
// Tracks two playback buffers and issues fill, pad and output commands.
// ----------------------------------------------------------------------------
// Usage:
//   evt : event requests (start, buffer filled, buffer finished playing).
//   res : one command result for every accepted event request.
//   cfg : writes the buffer size in samples; 0 is taken as 1 and values
//         above the maximum are clamped. Write it only while idle.
// A result is registered at the edge that accepts the event and is presented
// on the following cycle. Throughput is one event per cycle while the receiver
// keeps up, set by the single result register; evt.ready stays high while the
// result register is empty or being drained in the same cycle.
// If the receiver stalls, the result holds and evt.ready drops until it is
// taken; no event is lost.
// Reset puts both buffers in the empty phase with zero fill levels, sets the
// buffer size to 256 samples and empties the result register.
// An illegal event yields a result with only event_error set and leaves the
// buffer state unchanged.
// ----------------------------------------------------------------------------
module audio_ping_pong_buffer_controller_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    appbc_event_if.sink           evt,
    appbc_result_if.source        res,
    appbc_cfg_if.sink             cfg
);

    logic [appbc_pkg::COUNT_W-1:0] samples_reg;
    logic [appbc_pkg::COUNT_W-1:0] samples_next;

    appbc_pkg::phase_t             phase_reg [2];
    appbc_pkg::phase_t             phase_next [2];
    logic [appbc_pkg::COUNT_W-1:0] level_reg [2];
    logic [appbc_pkg::COUNT_W-1:0] level_next [2];

    logic                          res_valid_reg;
    appbc_pkg::result_t            res_data_reg;
    appbc_pkg::result_t            res_data_next;

    logic                          evt_take;
    logic                          b;
    logic                          other;
    logic [appbc_pkg::COUNT_W-1:0] count;

    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_take  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    assign b     = evt.data.buf_index;
    assign other = ~evt.data.buf_index;
    assign count = evt.data.fill_count;

    always_comb
    begin
        if (cfg.data == '0)
        begin
            samples_next = appbc_pkg::SAMPLES_MIN;
        end
        else if (cfg.data > appbc_pkg::SAMPLES_MAX)
        begin
            samples_next = appbc_pkg::SAMPLES_MAX;
        end
        else
        begin
            samples_next = cfg.data;
        end
    end

    always_comb
    begin
        logic err;

        err           = 1'b0;
        phase_next    = phase_reg;
        level_next    = level_reg;
        res_data_next = '0;

        case (evt.data.kind)
            appbc_pkg::KIND_START:
            begin
                if (phase_reg[0] == appbc_pkg::PH_EMPTY &&
                    phase_reg[1] == appbc_pkg::PH_EMPTY)
                begin
                    phase_next[0]              = appbc_pkg::PH_FILLING;
                    res_data_next.fill_request = 1'b1;
                    res_data_next.fill_target  = 1'b0;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            appbc_pkg::KIND_FILLED:
            begin
                if (phase_reg[b] != appbc_pkg::PH_FILLING || count > samples_reg ||
                    (phase_reg[other] != appbc_pkg::PH_EMPTY &&
                     phase_reg[other] != appbc_pkg::PH_PLAYING))
                begin
                    err = 1'b1;
                end
                else
                begin
                    level_next[b] = count;
                    phase_next[b] = appbc_pkg::PH_FULL;
                    if (count < samples_reg)
                    begin
                        res_data_next.pad_needed = 1'b1;
                        res_data_next.pad_start  = count;
                    end
                    if (phase_reg[other] == appbc_pkg::PH_EMPTY)
                    begin
                        // The first full buffer always plays from buffer 0,
                        // so a fill of buffer 1 is moved there with its count.
                        if (b)
                        begin
                            res_data_next.move_to_first = 1'b1;
                            level_next[0]               = count;
                            phase_next[1]               = appbc_pkg::PH_EMPTY;
                        end
                        res_data_next.output_start = 1'b1;
                        phase_next[0]              = appbc_pkg::PH_PLAYING;
                        if (count == samples_reg)
                        begin
                            phase_next[1]              = appbc_pkg::PH_FILLING;
                            res_data_next.fill_request = 1'b1;
                            res_data_next.fill_target  = 1'b1;
                        end
                    end
                end
            end
            appbc_pkg::KIND_PLAYED:
            begin
                if (phase_reg[b] != appbc_pkg::PH_PLAYING ||
                    phase_reg[other] == appbc_pkg::PH_PLAYING)
                begin
                    err = 1'b1;
                end
                else
                begin
                    phase_next[b] = appbc_pkg::PH_EMPTY;
                    if (phase_reg[other] == appbc_pkg::PH_FULL)
                    begin
                        phase_next[other] = appbc_pkg::PH_PLAYING;
                        // A short buffer marks end of stream: no refill after it.
                        if (level_reg[other] == samples_reg)
                        begin
                            phase_next[b]              = appbc_pkg::PH_FILLING;
                            res_data_next.fill_request = 1'b1;
                            res_data_next.fill_target  = b;
                        end
                    end
                    else if (phase_reg[other] == appbc_pkg::PH_FILLING)
                    begin
                        res_data_next.output_stop = 1'b1;
                        res_data_next.underrun    = 1'b1;
                    end
                    else
                    begin
                        res_data_next.output_stop = 1'b1;
                        res_data_next.stream_done = 1'b1;
                    end
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        if (err)
        begin
            phase_next                = phase_reg;
            level_next                = level_reg;
            res_data_next             = '0;
            res_data_next.event_error = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg   <= appbc_pkg::SAMPLES_RESET;
            phase_reg[0]  <= appbc_pkg::PH_EMPTY;
            phase_reg[1]  <= appbc_pkg::PH_EMPTY;
            level_reg[0]  <= '0;
            level_reg[1]  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                samples_reg <= samples_next;
            end
            if (evt_take)
            begin
                phase_reg     <= phase_next;
                level_reg     <= level_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            res_data_reg <= res_data_next;
        end
    end

endmodule

// File: dv/audio_ping_pong_buffer_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// audio_ping_pong_buffer_controller_unit_tb
// Self-checking bench for the ping-pong playback buffer controller. A model of
// the two buffer phases and fill levels predicts one command result for each
// event request. A directed pass walks the start, fill, play, underrun, move,
// pad and error paths. Random phases follow, mostly legal event streams with
// some noise, each under a different buffer size including the clamp cases.
// ----------------------------------------------------------------------------
module audio_ping_pong_buffer_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Tracks buffer state, predicts command results and checks the block.
    class command_scoreboard;
        appbc_pkg::phase_t                 phase [2];
        logic [appbc_pkg::COUNT_W-1:0]     level [2];
        logic [appbc_pkg::COUNT_W-1:0]     samples;
        appbc_pkg::result_t                expected_commands [$];
        int                                errors;

        function new();
            phase[0] = appbc_pkg::PH_EMPTY;
            phase[1] = appbc_pkg::PH_EMPTY;
            level[0] = '0;
            level[1] = '0;
            samples  = appbc_pkg::SAMPLES_RESET;
            errors   = 0;
        endfunction

        function void set_size(logic [appbc_pkg::COUNT_W-1:0] value);
            if (value < appbc_pkg::SAMPLES_MIN)
                samples = appbc_pkg::SAMPLES_MIN;
            else if (value > appbc_pkg::SAMPLES_MAX)
                samples = appbc_pkg::SAMPLES_MAX;
            else
                samples = value;
        endfunction

        // A complete buffer that starts playing asks for its partner.
        function void begin_playback(int p, inout appbc_pkg::result_t r);
            phase[p] = appbc_pkg::PH_PLAYING;
            if (level[p] == samples)
            begin
                phase[p ^ 1]   = appbc_pkg::PH_FILLING;
                r.fill_request = 1'b1;
                r.fill_target  = 1'(p ^ 1);
            end
        endfunction

        function appbc_pkg::result_t predict_commands(appbc_pkg::event_t ev);
            appbc_pkg::result_t r;
            int                 b;
            int                 o;
            bit                 legal;
            r     = '0;
            b     = int'(ev.buf_index);
            o     = b ^ 1;
            legal = 1'b1;
            if (ev.kind == appbc_pkg::KIND_START)
            begin
                if (phase[0] == appbc_pkg::PH_EMPTY && phase[1] == appbc_pkg::PH_EMPTY)
                begin
                    phase[0]       = appbc_pkg::PH_FILLING;
                    r.fill_request = 1'b1;
                    r.fill_target  = 1'b0;
                end
                else
                    legal = 1'b0;
            end
            else if (ev.kind == appbc_pkg::KIND_FILLED)
            begin
                if (phase[b] != appbc_pkg::PH_FILLING || ev.fill_count > samples ||
                    (phase[o] != appbc_pkg::PH_EMPTY && phase[o] != appbc_pkg::PH_PLAYING))
                    legal = 1'b0;
                else
                begin
                    level[b] = ev.fill_count;
                    phase[b] = appbc_pkg::PH_FULL;
                    if (ev.fill_count < samples)
                    begin
                        r.pad_needed = 1'b1;
                        r.pad_start  = ev.fill_count;
                    end
                    if (phase[o] == appbc_pkg::PH_EMPTY)
                    begin
                        // A first fill into buffer 1 is moved down with its count.
                        if (b == 1)
                        begin
                            r.move_to_first = 1'b1;
                            phase[0]        = appbc_pkg::PH_FULL;
                            level[0]        = ev.fill_count;
                            phase[1]        = appbc_pkg::PH_EMPTY;
                        end
                        r.output_start = 1'b1;
                        begin_playback(0, r);
                    end
                end
            end
            else if (ev.kind == appbc_pkg::KIND_PLAYED)
            begin
                if (phase[b] != appbc_pkg::PH_PLAYING || phase[o] == appbc_pkg::PH_PLAYING)
                    legal = 1'b0;
                else
                begin
                    phase[b] = appbc_pkg::PH_EMPTY;
                    if (phase[o] == appbc_pkg::PH_FULL)
                        begin_playback(o, r);
                    else if (phase[o] == appbc_pkg::PH_FILLING)
                    begin
                        r.output_stop = 1'b1;
                        r.underrun    = 1'b1;
                    end
                    else
                    begin
                        r.output_stop = 1'b1;
                        r.stream_done = 1'b1;
                    end
                end
            end
            else
                legal = 1'b0;
            if (!legal)
            begin
                r             = '0;
                r.event_error = 1'b1;
            end
            return r;
        endfunction

        function void note_event(appbc_pkg::event_t ev);
            expected_commands.push_back(predict_commands(ev));
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_command(appbc_pkg::result_t got);
            appbc_pkg::result_t exp_r;
            if (expected_commands.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, got);
                return;
            end
            exp_r = expected_commands.pop_front();
            if ($isunknown(got))
            begin
                errors++;
                $display("%0t: unknown result bits, expected %h, actual %h",
                         $time, exp_r, got);
            end
            compare_field("fill_request",  int'(exp_r.fill_request),
                          int'(got.fill_request));
            compare_field("fill_target",   int'(exp_r.fill_target),
                          int'(got.fill_target));
            compare_field("pad_needed",    int'(exp_r.pad_needed),
                          int'(got.pad_needed));
            compare_field("pad_start",     int'(exp_r.pad_start),
                          int'(got.pad_start));
            compare_field("move_to_first", int'(exp_r.move_to_first),
                          int'(got.move_to_first));
            compare_field("output_start",  int'(exp_r.output_start),
                          int'(got.output_start));
            compare_field("output_stop",   int'(exp_r.output_stop),
                          int'(got.output_stop));
            compare_field("underrun",      int'(exp_r.underrun),
                          int'(got.underrun));
            compare_field("stream_done",   int'(exp_r.stream_done),
                          int'(got.stream_done));
            compare_field("event_error",   int'(exp_r.event_error),
                          int'(got.event_error));
        endfunction
    endclass

    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int LONG_HOLD       = 200;

    logic clk;
    logic rst_n;
    bit   steady;
    bit   hold_off;

    command_scoreboard sb;

    appbc_event_if  evt_ch ();
    appbc_result_if res_ch ();
    appbc_cfg_if    cfg_ch ();

    audio_ping_pong_buffer_controller_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                sb.check_command(res_ch.data);
            if (evt_ch.valid && evt_ch.ready)
                sb.note_event(evt_ch.data);
        end
    end

    // Result receiver: random stalls, one long hold-off once it is asked for.
    initial
    begin
        int stall;
        bit long_done;
        stall        = 0;
        long_done    = 1'b0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off && !long_done)
            begin
                stall     = LONG_HOLD;
                long_done = 1'b1;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else if (steady || $urandom_range(99) < 70)
                res_ch.ready <= 1'b1;
            else
            begin
                res_ch.ready <= 1'b0;
                stall = ($urandom_range(9) == 0) ? int'($urandom_range(40, 10))
                                                 : int'($urandom_range(2, 0));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(99));
        if (steady || r < 65)
            return 0;
        else if (r < 90)
            return int'($urandom_range(3, 1));
        else
            return int'($urandom_range(40, 8));
    endfunction

    function automatic appbc_pkg::event_t ev_of(appbc_pkg::kind_t k, logic b, int n);
        appbc_pkg::event_t ev;
        ev.kind       = k;
        ev.buf_index  = b;
        ev.fill_count = appbc_pkg::COUNT_W'(n);
        return ev;
    endfunction

    // Mostly a legal next event for the tracked state, sometimes random noise.
    function automatic appbc_pkg::event_t pick_event();
        appbc_pkg::event_t             ev;
        appbc_pkg::kind_t              cand_kind [3];
        logic                          cand_buf [3];
        int                            n;
        int                            pick;
        int                            r;
        logic [appbc_pkg::COUNT_W-1:0] s;
        n = 0;
        s = sb.samples;
        if (sb.phase[0] == appbc_pkg::PH_EMPTY && sb.phase[1] == appbc_pkg::PH_EMPTY)
        begin
            cand_kind[n] = appbc_pkg::KIND_START;
            cand_buf[n]  = 1'($urandom);
            n++;
        end
        for (int b = 0; b < 2; b++)
        begin
            if (sb.phase[b] == appbc_pkg::PH_FILLING &&
                (sb.phase[b ^ 1] == appbc_pkg::PH_EMPTY ||
                 sb.phase[b ^ 1] == appbc_pkg::PH_PLAYING))
            begin
                cand_kind[n] = appbc_pkg::KIND_FILLED;
                cand_buf[n]  = 1'(b);
                n++;
            end
            if (sb.phase[b] == appbc_pkg::PH_PLAYING &&
                sb.phase[b ^ 1] != appbc_pkg::PH_PLAYING)
            begin
                cand_kind[n] = appbc_pkg::KIND_PLAYED;
                cand_buf[n]  = 1'(b);
                n++;
            end
        end
        if (n == 0 || $urandom_range(99) < 12)
        begin
            ev.kind       = appbc_pkg::KIND_W'($urandom);
            ev.buf_index  = 1'($urandom);
            ev.fill_count = appbc_pkg::COUNT_W'($urandom);
            return ev;
        end
        pick          = int'($urandom_range(n - 1));
        ev.kind       = cand_kind[pick];
        ev.buf_index  = cand_buf[pick];
        ev.fill_count = appbc_pkg::COUNT_W'($urandom);
        if (cand_kind[pick] == appbc_pkg::KIND_FILLED)
        begin
            r = int'($urandom_range(99));
            if (r < 75)
                ev.fill_count = s;
            else
                ev.fill_count = appbc_pkg::COUNT_W'($urandom_range(int'(s) - 1, 0));
        end
        return ev;
    endfunction

    // Called and returns at a falling edge; the request is held until taken.
    task automatic send_event(appbc_pkg::event_t ev);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= ev;
        do
            @(posedge clk);
        while (evt_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic drain();
        evt_ch.valid <= 1'b0;
        while (sb.expected_commands.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_size(logic [appbc_pkg::COUNT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.set_size(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int size_plan [PHASE_COUNT];
        sb            = new();
        steady        = 1'b0;
        hold_off      = 1'b0;
        rst_n         = 1'b0;
        evt_ch.valid  = 1'b0;
        evt_ch.data   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        size_plan     = '{1, 4096, 0, 8191, 2, 5000, 4095, 0};
        size_plan[7]  = int'($urandom_range(4094, 3));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pass at the reset size of 256 samples.
        send_event(ev_of(appbc_pkg::KIND_START,  1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_START,  1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b0, 256));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b1, 100));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_START,  1'b1, 0));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b0, 8191));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b0, 257));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b1, 256));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b0, 256));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b1, 0));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b1, 0));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b1, 0));
        send_event(ev_of(appbc_pkg::KIND_NONE,   1'b1, 4096));
        send_event(ev_of(appbc_pkg::KIND_START,  1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b0, 256));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b1, 256));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b0, 0));
        send_event(ev_of(appbc_pkg::KIND_FILLED, 1'b0, 255));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b1, 0));
        send_event(ev_of(appbc_pkg::KIND_PLAYED, 1'b0, 0));

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            write_size(appbc_pkg::COUNT_W'(size_plan[ph]));
            steady = (ph == 2 || ph == 5);
            // One phase keeps offering requests while the results are held off.
            if (ph == 1)
                hold_off = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_event(pick_event());
        end
        drain();

        if (sb.errors == 0 && sb.expected_commands.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/appbc_pkg.sv
sv/appbc_if.sv
sv/audio_ping_pong_buffer_controller_unit.sv
dv/audio_ping_pong_buffer_controller_unit_tb.sv
